// File: rtl/core/hswb_pkg.sv
// Package with constants, payload types and the lane control type.
package hswb_pkg;

  localparam int unsigned MaxPixelsLog2Def = 22;
  localparam int unsigned NumBins = 256;
  localparam int unsigned BinIdxW = 8;
  localparam int unsigned PermilleW = 9;
  localparam logic [PermilleW-1:0] PermilleReset = 9'd50;

  // Item kinds.
  localparam logic [1:0] KindStats = 2'd0;
  localparam logic [1:0] KindBounds = 2'd1;
  localparam logic [1:0] KindStretch = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_item_t;

  typedef struct packed {
    logic       is_bounds;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [7:0] blue_low;
    logic [7:0] blue_high;
    logic [7:0] green_low;
    logic [7:0] green_high;
    logic [7:0] red_low;
    logic [7:0] red_high;
  } out_item_t;

  // Control from the sequencer to every channel lane.
  typedef struct packed {
    logic       stat_en;
    logic [7:0] scan_idx;
    logic       scan_en;
    logic       scan_first;
    logic       clear_en;
    logic       div_start;
  } lane_ctrl_t;

endpackage

// File: rtl/core/histogram_stretch_white_balance.sv
// Top level: sequencer, three channel lanes and the result merge.
// A statistics pixel is counted only while the frame has room and gives no result.
// A stretch pixel's result is strobed when the 16-step divider in each lane ends.
// A bounds item's result is strobed when the scan ends; the next item is taken when
// the clearing sweep that follows the scan ends.
// Asynchronous reset starts a clearing sweep; the receiver cannot stall.
module histogram_stretch_white_balance #(
  parameter int unsigned MaxPixelsLog2 = hswb_pkg::MaxPixelsLog2Def
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  hswb_pkg::in_item_t                   item_i,
  output logic                                 done_o,
  output hswb_pkg::out_item_t                  result_o,
  input  logic                                 cfg_we_i,
  input  logic [hswb_pkg::PermilleW-1:0]       cfg_wdata_i
);

  localparam int unsigned CntW = MaxPixelsLog2 + 1;
  localparam int unsigned ThrW = CntW + 10;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StStat  = 5'b00010,
    StScan  = 5'b00100,
    StClear = 5'b01000,
    StDiv   = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [8:0]           cnt_q, cnt_d;
  logic [CntW-1:0]      npix_q;
  logic [8:0]           perm_q;
  hswb_pkg::in_item_t   item_q;
  hswb_pkg::lane_ctrl_t ctrl;
  hswb_pkg::out_item_t  res;
  logic                 done_q;
  logic [ThrW-1:0]      lo_thr, hi_thr;
  logic [7:0]           lo_v [3];
  logic [7:0]           hi_v [3];
  logic [7:0]           q_v [3];
  logic [7:0]           pix_v [3];
  logic                 accept;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  assign lo_thr = ThrW'(perm_q) * ThrW'(npix_q);
  assign hi_thr = ThrW'(11'd1000 - 11'(perm_q)) * ThrW'(npix_q);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctrl    = '0;
    ctrl.scan_idx = cnt_q[7:0];
    case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (accept) begin
          case (item_i.kind)
            hswb_pkg::KindStats: begin
              if (npix_q[CntW-1] == 1'b0) begin
                state_d = StStat;
              end
            end
            hswb_pkg::KindBounds:  state_d = StScan;
            hswb_pkg::KindStretch: state_d = StDiv;
            default: state_d = StIdle;
          endcase
        end
        ctrl.stat_en = 1'b0;
      end
      StStat: begin
        ctrl.stat_en = 1'b1;
        state_d = StIdle;
      end
      StScan: begin
        ctrl.scan_en    = (cnt_q < 9'd256);
        ctrl.scan_first = (cnt_q == 9'd0);
        cnt_d = cnt_q + 9'd1;
        if (cnt_q == 9'd257) begin
          state_d = StClear;
          cnt_d = '0;
        end
      end
      StClear: begin
        ctrl.clear_en = 1'b1;
        cnt_d = cnt_q + 9'd1;
        if (cnt_q == 9'd255) state_d = StIdle;
      end
      StDiv: begin
        ctrl.div_start = (cnt_q == 9'd0);
        cnt_d = cnt_q + 9'd1;
        if (cnt_q == 9'd16) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Statistics read is issued on accept while the frame still has room.
  logic stat_rd;
  assign stat_rd = accept && item_i.kind == hswb_pkg::KindStats && !npix_q[CntW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cnt_q   <= '0;
      npix_q  <= '0;
      perm_q  <= hswb_pkg::PermilleReset;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) perm_q <= cfg_wdata_i;
      if (state_q == StStat) npix_q <= npix_q + CntW'(1);
      if (state_q == StClear && cnt_q == 9'd255) npix_q <= '0;
      done_q <= (state_q == StScan && cnt_q == 9'd257) ||
                (state_q == StDiv && cnt_q == 9'd16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_i;
  end

  // Lanes read the pixel at accept for statistics and at division start.
  assign pix_v[0] = accept ? item_i.blue_in  : item_q.blue_in;
  assign pix_v[1] = accept ? item_i.green_in : item_q.green_in;
  assign pix_v[2] = accept ? item_i.red_in   : item_q.red_in;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    hswb_pkg::lane_ctrl_t lc;
    always_comb begin
      lc = ctrl;
      lc.scan_en = ctrl.scan_en | stat_rd;
      lc.stat_en = ctrl.stat_en | stat_rd;
    end
    hswb_lane #(.MaxPixelsLog2(MaxPixelsLog2)) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lc),
      .pix_i    (pix_v[g]),
      .lo_thr_i (lo_thr),
      .hi_thr_i (hi_thr),
      .low_o    (lo_v[g]),
      .high_o   (hi_v[g]),
      .quot_o   (q_v[g])
    );
  end

  // Merge: assemble the result from the three lanes.
  always_comb begin
    res = '0;
    if (item_q.kind == hswb_pkg::KindBounds) begin
      res.is_bounds  = 1'b1;
      res.blue_low   = lo_v[0];
      res.blue_high  = hi_v[0];
      res.green_low  = lo_v[1];
      res.green_high = hi_v[1];
      res.red_low    = lo_v[2];
      res.red_high   = hi_v[2];
    end else begin
      res.blue_out  = q_v[0];
      res.green_out = q_v[1];
      res.red_out   = q_v[2];
    end
  end

  assign done_o   = done_q;
  assign result_o = res;

endmodule

// File: rtl/core/hswb_lane.sv
// One color channel: histogram memory, bound search and stretch divider.
module hswb_lane #(
  parameter int unsigned MaxPixelsLog2 = hswb_pkg::MaxPixelsLog2Def,
  localparam int unsigned CntW = MaxPixelsLog2 + 1,
  localparam int unsigned ThrW = CntW + 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hswb_pkg::lane_ctrl_t ctrl_i,
  input  logic [7:0]           pix_i,
  input  logic [ThrW-1:0]      lo_thr_i,
  input  logic [ThrW-1:0]      hi_thr_i,
  output logic [7:0]           low_o,
  output logic [7:0]           high_o,
  output logic [7:0]           quot_o
);

  logic [CntW-1:0] bins_q [hswb_pkg::NumBins];
  logic [CntW-1:0] rd_q;
  logic [CntW-1:0] cum_q, cum_d;
  logic            lo_found_q;
  logic [7:0]      low_q, high_q;
  logic            hi_any_q;
  logic [ThrW-1:0] cum_k;
  logic            rd_vld_q;
  logic [7:0]      rd_idx_q;
  logic            rd_first_q;

  // Histogram memory: read-modify-write for statistics, swept for scan and clear.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear_en) begin
      bins_q[ctrl_i.scan_idx] <= '0;
    end else if (ctrl_i.stat_en && rd_vld_q) begin
      bins_q[rd_idx_q] <= rd_q + CntW'(1);
    end
    rd_q <= bins_q[ctrl_i.stat_en ? pix_i : ctrl_i.scan_idx];
  end

  // Statistics use a two step update; the sequencer spaces statistics pixels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      rd_first_q <= 1'b0;
    end else begin
      rd_vld_q   <= ctrl_i.scan_en;
      rd_idx_q   <= ctrl_i.stat_en ? pix_i : ctrl_i.scan_idx;
      rd_first_q <= ctrl_i.scan_first;
    end
  end

  assign cum_d = (rd_first_q ? '0 : cum_q) + rd_q;
  assign cum_k = ThrW'(cum_d) * ThrW'(1000);

  // Bound search over the running cumulative sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cum_q      <= '0;
      lo_found_q <= 1'b0;
      hi_any_q   <= 1'b0;
      low_q      <= '0;
      high_q     <= 8'd255;
    end else if (rd_vld_q && !ctrl_i.stat_en) begin
      cum_q <= cum_d;
      if (rd_first_q) begin
        lo_found_q <= 1'b0;
        hi_any_q   <= 1'b0;
        low_q      <= 8'd255;
      end
      if ((rd_first_q || !lo_found_q) && cum_k >= lo_thr_i) begin
        lo_found_q <= 1'b1;
        low_q      <= rd_idx_q;
      end
      if (cum_k <= hi_thr_i) begin
        hi_any_q <= 1'b1;
        high_q   <= (rd_idx_q < 8'd254) ? rd_idx_q + 8'd1 : rd_idx_q;
      end else if (rd_first_q) begin
        hi_any_q <= 1'b0;
        high_q   <= 8'd0;
      end else if (!hi_any_q) begin
        high_q <= 8'd0;
      end
    end
  end

  assign low_o  = low_q;
  assign high_o = high_q;

  // Stretch: restoring divider, one quotient bit per cycle.
  logic [15:0] num_q;
  logic [7:0]  den_q;
  logic [16:0] rem_q;
  logic [7:0]  quo_q;
  logic [7:0]  xc;
  logic [16:0] trial;

  always_comb begin
    xc = pix_i;
    if (xc < low_q)  xc = low_q;
    if (xc > high_q) xc = high_q;
  end

  assign trial = {rem_q[15:0], num_q[15]} - {9'd0, den_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      num_q <= 16'(xc - low_q) * 16'd255;
      den_q <= (high_q > low_q) ? high_q - low_q : 8'd0;
      rem_q <= '0;
      quo_q <= '0;
    end else begin
      num_q <= {num_q[14:0], 1'b0};
      if (!trial[16] && den_q != 8'd0) begin
        rem_q <= trial;
        quo_q <= {quo_q[6:0], 1'b1};
      end else begin
        rem_q <= {rem_q[15:0], num_q[15]};
        quo_q <= {quo_q[6:0], 1'b0};
      end
    end
  end

  assign quot_o = quo_q;

endmodule

// File: verif/testbench.sv
// Testbench for the percentile-stretch white balance block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int unsigned TargetItems = 900;
  localparam int unsigned IdleAfterDrain = 600;

  // How a directed row gets its expected transaction.
  typedef enum logic [1:0] {RowPredicted, RowTyped, RowSkipped} row_mode_e;

  typedef struct packed {
    hswb_pkg::in_item_t  item;
    row_mode_e           mode;
    hswb_pkg::out_item_t typed;
  } stim_row_t;

  typedef struct packed {
    logic                skip;
    hswb_pkg::out_item_t value;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  hswb_pkg::in_item_t item = '0;
  logic done;
  hswb_pkg::out_item_t result;
  logic cfg_we = 1'b0;
  logic [hswb_pkg::PermilleW-1:0] cfg_wdata = '0;

  // Model state: histograms, pixel count, bounds and the discard share.
  int unsigned hist [3][hswb_pkg::NumBins];
  longint unsigned frame_pixels;
  logic [7:0] bound_low [3];
  logic [7:0] bound_high [3];
  logic [hswb_pkg::PermilleW-1:0] share;

  pending_t pending_q [$];
  int unsigned mismatches = 0;
  int unsigned sent = 0;

  histogram_stretch_white_balance uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .item_i     (item),
    .done_o     (done),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Derive the clip bounds of one channel from its histogram.
  task automatic find_clip_bounds(input int ch);
    longint unsigned cum [hswb_pkg::NumBins];
    longint unsigned acc;
    longint unsigned lo_thr;
    longint unsigned hi_thr;
    int lo;
    int hi;
    acc = 0;
    lo_thr = longint'(share) * frame_pixels;
    hi_thr = (1000 - longint'(share)) * frame_pixels;
    for (int b = 0; b < hswb_pkg::NumBins; b++) begin
      acc += hist[ch][b];
      cum[b] = acc;
    end
    lo = 0;
    while (lo < 255 && cum[lo] * 1000 < lo_thr) lo++;
    hi = 255;
    while (hi >= 0 && cum[hi] * 1000 > hi_thr) hi--;
    if (hi < 254) hi++;
    bound_low[ch] = lo[7:0];
    bound_high[ch] = hi[7:0];
  endtask

  function automatic logic [7:0] stretch_component(input logic [7:0] v, input int ch);
    int unsigned x;
    int unsigned lo;
    int unsigned hi;
    lo = bound_low[ch];
    hi = bound_high[ch];
    x = v;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    if (hi <= lo) return 8'd0;
    return 8'(((x - lo) * 255) / (hi - lo));
  endfunction

  // Advance the model by one accepted item; returns 1 with a result.
  task automatic balance_predict(input hswb_pkg::in_item_t it, output bit has_result,
                                 output hswb_pkg::out_item_t res);
    has_result = 1'b0;
    res = '0;
    case (it.kind)
      hswb_pkg::KindStats: begin
        if (frame_pixels < (64'd1 << hswb_pkg::MaxPixelsLog2Def)) begin
          hist[0][it.blue_in]++;
          hist[1][it.green_in]++;
          hist[2][it.red_in]++;
          frame_pixels++;
        end
      end
      hswb_pkg::KindBounds: begin
        for (int ch = 0; ch < 3; ch++) find_clip_bounds(ch);
        foreach (hist[c, b]) hist[c][b] = 0;
        frame_pixels = 0;
        has_result = 1'b1;
        res.is_bounds = 1'b1;
        res.blue_low = bound_low[0];
        res.blue_high = bound_high[0];
        res.green_low = bound_low[1];
        res.green_high = bound_high[1];
        res.red_low = bound_low[2];
        res.red_high = bound_high[2];
      end
      hswb_pkg::KindStretch: begin
        has_result = 1'b1;
        res.blue_out = stretch_component(it.blue_in, 0);
        res.green_out = stretch_component(it.green_in, 1);
        res.red_out = stretch_component(it.red_in, 2);
      end
      default: ;
    endcase
  endtask

  // Hand one item over; start stays high when the next one follows at once.
  task automatic send_item(input hswb_pkg::in_item_t it, input row_mode_e mode,
                           input hswb_pkg::out_item_t typed);
    int unsigned gap;
    bit has_result;
    hswb_pkg::out_item_t res;
    pending_t p;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    balance_predict(it, has_result, res);
    if (it.kind != KindUnused) sent++;
    if (has_result) begin
      p.skip = (mode == RowSkipped);
      p.value = (mode == RowTyped) ? typed : res;
      pending_q.push_back(p);
    end
  endtask

  // Write the share register once the block has gone idle.
  task automatic write_share(input logic [hswb_pkg::PermilleW-1:0] value);
    start <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (IdleAfterDrain) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    share = value;
  endtask

  // Compare every strobed transaction with the oldest expectation.
  always @(posedge clk) begin
    pending_t p;
    if (rst_n && done === 1'b1) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transaction: %p", result);
      end else begin
        p = pending_q.pop_front();
        if (!p.skip && (result.is_bounds !== p.value.is_bounds ||
            result.blue_out !== p.value.blue_out ||
            result.green_out !== p.value.green_out ||
            result.red_out !== p.value.red_out ||
            result.blue_low !== p.value.blue_low ||
            result.blue_high !== p.value.blue_high ||
            result.green_low !== p.value.green_low ||
            result.green_high !== p.value.green_high ||
            result.red_low !== p.value.red_low ||
            result.red_high !== p.value.red_high)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Transaction mismatch: expected %p, got %p", p.value, result);
        end
      end
    end
  end

  function automatic hswb_pkg::in_item_t mk(input logic [1:0] k, input logic [7:0] b,
                                            input logic [7:0] g, input logic [7:0] r);
    hswb_pkg::in_item_t it;
    it.kind = k;
    it.blue_in = b;
    it.green_in = g;
    it.red_in = r;
    return it;
  endfunction

  function automatic hswb_pkg::out_item_t bounds_val(input logic [7:0] lo,
                                                     input logic [7:0] hi);
    hswb_pkg::out_item_t o;
    o = '0;
    o.is_bounds = 1'b1;
    o.blue_low = lo;
    o.blue_high = hi;
    o.green_low = lo;
    o.green_high = hi;
    o.red_low = lo;
    o.red_high = hi;
    return o;
  endfunction

  function automatic hswb_pkg::out_item_t pixel_val(input logic [7:0] b,
                                                    input logic [7:0] g,
                                                    input logic [7:0] r);
    hswb_pkg::out_item_t o;
    o = '0;
    o.blue_out = b;
    o.green_out = g;
    o.red_out = r;
    return o;
  endfunction

  initial begin
    stim_row_t rows [$];
    logic [7:0] base [3];
    logic [7:0] span [3];
    logic [7:0] px [3];
    int unsigned n_stats;
    int unsigned n_stretch;
    int unsigned pick;

    foreach (hist[c, b]) hist[c][b] = 0;
    frame_pixels = 0;
    for (int ch = 0; ch < 3; ch++) begin
      bound_low[ch] = 8'd0;
      bound_high[ch] = 8'd255;
    end
    share = hswb_pkg::PermilleReset;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Right after reset the frame is empty and the bounds span the full range.
    rows.push_back('{mk(hswb_pkg::KindBounds, 0, 0, 0), RowTyped, bounds_val(0, 255)});
    // An empty frame gives the full range, and stretching is then identity.
    rows.push_back('{mk(hswb_pkg::KindBounds, 0, 0, 0), RowTyped, bounds_val(0, 255)});
    rows.push_back('{mk(hswb_pkg::KindStretch, 0, 0, 0), RowTyped, pixel_val(0, 0, 0)});
    rows.push_back('{mk(hswb_pkg::KindStretch, 255, 255, 255), RowTyped,
                     pixel_val(255, 255, 255)});
    rows.push_back('{mk(hswb_pkg::KindStretch, 8'haa, 8'h55, 8'h0f), RowTyped,
                     pixel_val(8'haa, 8'h55, 8'h0f)});
    // Unused kind does nothing.
    rows.push_back('{mk(KindUnused, 8'hff, 8'hff, 8'hff), RowPredicted, '0});
    // Frame of extreme values.
    rows.push_back('{mk(hswb_pkg::KindStats, 0, 255, 8'h80), RowPredicted, '0});
    rows.push_back('{mk(hswb_pkg::KindStats, 255, 0, 8'h7f), RowPredicted, '0});
    rows.push_back('{mk(hswb_pkg::KindStats, 8'h55, 8'haa, 8'h80), RowPredicted, '0});
    rows.push_back('{mk(hswb_pkg::KindStats, 8'haa, 8'h55, 8'h81), RowPredicted, '0});
    rows.push_back('{mk(hswb_pkg::KindBounds, 0, 0, 0), RowPredicted, '0});
    rows.push_back('{mk(hswb_pkg::KindStretch, 0, 255, 8'h80), RowPredicted, '0});
    rows.push_back('{mk(hswb_pkg::KindStretch, 255, 0, 8'h7f), RowPredicted, '0});
    rows.push_back('{mk(hswb_pkg::KindStretch, 8'h60, 8'h90, 8'hc0), RowPredicted, '0});
    // All pixels equal: bounds collapse and stretch gives zero.
    rows.push_back('{mk(hswb_pkg::KindStats, 8'h40, 8'h40, 8'h40), RowPredicted, '0});
    rows.push_back('{mk(hswb_pkg::KindStats, 8'h40, 8'h40, 8'h40), RowPredicted, '0});
    rows.push_back('{mk(hswb_pkg::KindBounds, 0, 0, 0), RowPredicted, '0});
    rows.push_back('{mk(hswb_pkg::KindStretch, 8'h40, 0, 255), RowPredicted, '0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].mode, rows[i].typed);

    // Share at zero: a one-pixel frame at bin zero keeps the full range.
    write_share(9'd0);
    send_item(mk(hswb_pkg::KindStats, 0, 0, 0), RowPredicted, '0);
    send_item(mk(hswb_pkg::KindBounds, 0, 0, 0), RowPredicted, '0);
    send_item(mk(hswb_pkg::KindStretch, 0, 8'h10, 255), RowPredicted, '0);

    // Default share with the whole frame at bin zero: high falls to zero, giving 0.
    write_share(hswb_pkg::PermilleReset);
    send_item(mk(hswb_pkg::KindStats, 0, 0, 0), RowPredicted, '0);
    send_item(mk(hswb_pkg::KindBounds, 0, 0, 0), RowTyped, bounds_val(0, 0));
    send_item(mk(hswb_pkg::KindStretch, 0, 8'h10, 255), RowTyped, pixel_val(0, 0, 0));

    // Random frames, with the share changed now and then.
    while (sent < TargetItems) begin
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: write_share(9'd0);
          1: write_share(9'd499);
          2: write_share(9'd511);
          3: write_share(hswb_pkg::PermilleReset);
          default: write_share(9'($urandom_range(0, 511)));
        endcase
      end
      for (int ch = 0; ch < 3; ch++) begin
        base[ch] = 8'($urandom_range(0, 255));
        span[ch] = 8'($urandom_range(0, 255));
      end
      n_stats = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
      for (int i = 0; i < n_stats; i++) begin
        for (int ch = 0; ch < 3; ch++)
          px[ch] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                   : 8'(base[ch] + $urandom_range(0, span[ch]));
        if ($urandom_range(0, 19) == 0)
          send_item(mk(KindUnused, px[0], px[1], px[2]), RowPredicted, '0);
        send_item(mk(hswb_pkg::KindStats, px[0], px[1], px[2]), RowPredicted, '0);
      end
      send_item(mk(hswb_pkg::KindBounds, 8'($urandom), 8'($urandom), 8'($urandom)),
                RowPredicted, '0);
      n_stretch = $urandom_range(3, 20);
      for (int i = 0; i < n_stretch; i++)
        send_item(mk(hswb_pkg::KindStretch, 8'($urandom), 8'($urandom), 8'($urandom)),
                  RowPredicted, '0);
    end
    start <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (IdleAfterDrain) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
